// ===== sv/assert_macros.svh =====
// Assertion macros used by the top level of the white blob steering block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define WBCS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define WBCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== sv/wbcs_pkg.sv =====
// Package with the widths, constants, codes and control types of the steering block.
`default_nettype none

package wbcs_pkg;

  // Field and state widths.
  localparam int DIM_W  = 13;
  localparam int COL_W  = 12;
  localparam int IDX_W  = 24;
  localparam int SUM_W  = 35;
  localparam int CNT_W  = 23;
  localparam int N_W    = 25;
  localparam int LIM_W  = 24;
  localparam int MEAN_W = 12;
  localparam int CMD_W  = 2;
  localparam int CFG_IDX_W = 1;
  localparam int PIX_W  = 8;

  // Divider sequencing: one quotient bit per cycle.
  localparam int DIV_STEPS = MEAN_W;
  localparam int STEP_W    = 4;

  // Frame dimension limits and reset values.
  localparam int MAX_WIDTH    = 4096;
  localparam int MAX_HEIGHT   = 4096;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;
  localparam int RESET_N      = RESET_WIDTH * RESET_HEIGHT;
  localparam int RESET_LO     = RESET_N / 3;
  localparam int RESET_HI     = (RESET_N * 2) / 3;
  localparam int RESET_W3     = RESET_WIDTH / 3;
  localparam int RESET_W23    = (RESET_WIDTH * 2) / 3;

  localparam logic [PIX_W-1:0] WHITE_LEVEL = 8'd255;
  localparam logic [IDX_W-1:0] IDX_MAX     = {IDX_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX     = {SUM_W{1'b1}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  // Steering commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_STOP    = 2'd0,
    CMD_LEFT    = 2'd1,
    CMD_FORWARD = 2'd2,
    CMD_RIGHT   = 2'd3
  } steer_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cfg_we;
    logic acc_en;
    logic div_load;
    logic div_step;
    logic out_load;
    logic calc_mul;
    logic calc_div3;
  } wbcs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } wbcs_stat_t;

  // Exact floor(x / 3) for x below 2**26 by a reciprocal multiply.
  localparam logic [26:0] DIV3_RECIP = 27'h5555556;

  function automatic logic [24:0] div3(input logic [25:0] x);
    logic [52:0] prod;
    prod = x * DIV3_RECIP;
    return prod[52:28];
  endfunction

endpackage

`default_nettype wire

// ===== sv/wbcs_ctrl.sv =====
// Controller state machine: handshakes, limit recalculation and divide sequencing.
`default_nettype none

module wbcs_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               frame_end_i,
  output logic                    in_stall_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire wbcs_pkg::wbcs_stat_t stat_i,
  output wbcs_pkg::wbcs_cmd_t     cmd_o
);
  import wbcs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV3 = 2'd2;
  localparam logic [1:0] S_DIV  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              in_open;

  // Handshake and command decode.
  always_comb begin
    cfg_ready_o      = (state_q == S_IDLE);
    in_open          = ((state_q == S_IDLE) && !cfg_valid_i) ||
                       ((state_q == S_DIV) && !frame_end_i);
    in_stall_o       = !in_open;
    cmd_o.cfg_we     = cfg_valid_i && cfg_ready_o;
    cmd_o.acc_en     = in_valid_i && in_open;
    cmd_o.div_load   = cmd_o.acc_en && frame_end_i;
    cmd_o.div_step   = (state_q == S_DIV) && (step_q != '0);
    cmd_o.out_load   = (state_q == S_DIV) && (step_q == '0) && stat_i.out_free;
    cmd_o.calc_mul   = (state_q == S_MUL);
    cmd_o.calc_div3  = (state_q == S_DIV3);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.cfg_we) begin
          state_d = S_MUL;
        end else if (cmd_o.div_load) begin
          state_d = S_DIV;
          step_d  = STEP_W'(DIV_STEPS);
        end
      end
      S_MUL:  state_d = S_DIV3;
      S_DIV3: state_d = S_IDLE;
      S_DIV: begin
        if (cmd_o.div_step) begin
          step_d = step_q - 1'b1;
        end else if (cmd_o.out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/wbcs_dp.sv =====
// Datapath: configuration, derived limits, accumulators, divider and output register.
`default_nettype none

module wbcs_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire wbcs_pkg::wbcs_cmd_t                 cmd_i,
  output wbcs_pkg::wbcs_stat_t                     stat_o,
  input  wire logic [wbcs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [wbcs_pkg::DIM_W-1:0]          cfg_data_i,
  input  wire logic [wbcs_pkg::PIX_W-1:0]          red_level_i,
  input  wire logic [wbcs_pkg::PIX_W-1:0]          green_level_i,
  input  wire logic [wbcs_pkg::PIX_W-1:0]          blue_level_i,
  input  wire logic                                frame_end_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [wbcs_pkg::CMD_W-1:0]               steer_command_o,
  output logic [wbcs_pkg::MEAN_W-1:0]              mean_column_o,
  output logic [wbcs_pkg::CNT_W-1:0]               white_count_o
);
  import wbcs_pkg::*;

  logic [DIM_W-1:0]   width_q, height_q;
  logic [DIM_W-1:0]   wcl_q, wc, hc;
  logic [2*DIM_W-1:0] area;
  logic [N_W-1:0]     n_q;
  logic [LIM_W-1:0]   lo_q, hi_q;
  logic [MEAN_W-1:0]  w3_q, w23_q;

  logic [COL_W-1:0]   col_q, col_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [CNT_W-1:0]   tot_q, tot_d;
  logic [SUM_W:0]     sum_ext;
  logic               hit;

  logic [CNT_W-1:0]   dsr_q;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic [MEAN_W-1:0]  dvd_q, dvd_d;
  logic [CNT_W:0]     trial;
  logic               qbit;

  logic               out_valid_q;
  logic [CMD_W-1:0]   steer_q;
  logic [MEAN_W-1:0]  mean_q;
  logic [CNT_W-1:0]   count_q;
  steer_e             steer_d;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(RESET_WIDTH);
      height_q <= DIM_W'(RESET_HEIGHT);
    end else if (cmd_i.cfg_we) begin
      if (cfg_index_i == REG_FRAME_WIDTH) begin
        width_q <= cfg_data_i;
      end
      if (cfg_index_i == REG_FRAME_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  // Clamp the dimensions and form the frame area.
  always_comb begin
    wc = width_q;
    if (width_q == '0) begin
      wc = DIM_W'(1);
    end else if (width_q > DIM_W'(MAX_WIDTH)) begin
      wc = DIM_W'(MAX_WIDTH);
    end
    hc = height_q;
    if (height_q == '0) begin
      hc = DIM_W'(1);
    end else if (height_q > DIM_W'(MAX_HEIGHT)) begin
      hc = DIM_W'(MAX_HEIGHT);
    end
    area = wc * hc;
  end

  // Derived limits: area first, then the thirds in the following cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcl_q <= DIM_W'(RESET_WIDTH);
      n_q   <= N_W'(RESET_N);
      lo_q  <= LIM_W'(RESET_LO);
      hi_q  <= LIM_W'(RESET_HI);
      w3_q  <= MEAN_W'(RESET_W3);
      w23_q <= MEAN_W'(RESET_W23);
    end else begin
      if (cmd_i.calc_mul) begin
        wcl_q <= wc;
        n_q   <= N_W'(area);
      end
      if (cmd_i.calc_div3) begin
        lo_q  <= LIM_W'(div3({1'b0, n_q}));
        hi_q  <= LIM_W'(div3({n_q, 1'b0}));
        w3_q  <= MEAN_W'(div3(26'(wcl_q)));
        w23_q <= MEAN_W'(div3(26'({wcl_q, 1'b0})));
      end
    end
  end

  // Pixel accumulation with saturation and row wrap.
  always_comb begin
    hit = (idx_q >= lo_q) && (idx_q < hi_q) && (red_level_i == WHITE_LEVEL) &&
          (green_level_i == WHITE_LEVEL) && (blue_level_i == WHITE_LEVEL);
    tot_d   = tot_q;
    sum_d   = sum_q;
    sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(col_q);
    if (hit) begin
      if (tot_q != CNT_MAX) begin
        tot_d = tot_q + 1'b1;
      end
      sum_d = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
    end
    idx_d = (idx_q != IDX_MAX) ? idx_q + 1'b1 : idx_q;
    if (({1'b0, col_q} + 1'b1) >= wcl_q) begin
      col_d = '0;
    end else begin
      col_d = col_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      idx_q <= '0;
      sum_q <= '0;
      tot_q <= '0;
    end else if (cmd_i.acc_en) begin
      if (frame_end_i) begin
        col_q <= '0;
        idx_q <= '0;
        sum_q <= '0;
        tot_q <= '0;
      end else begin
        col_q <= col_d;
        idx_q <= idx_d;
        sum_q <= sum_d;
        tot_q <= tot_d;
      end
    end
  end

  // Restoring divider: the column sum over the count, one quotient bit per cycle.
  // The sum stays below count * 4096, so the upper part starts below the divisor.
  always_comb begin
    trial = {rem_q, dvd_q[MEAN_W-1]};
    qbit  = (trial >= {1'b0, dsr_q});
    rem_d = qbit ? CNT_W'(trial - {1'b0, dsr_q}) : trial[CNT_W-1:0];
    dvd_d = {dvd_q[MEAN_W-2:0], qbit};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      dsr_q <= tot_d;
      rem_q <= sum_d[SUM_W-1:MEAN_W];
      dvd_q <= sum_d[MEAN_W-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
    end
  end

  // Steering decision from the mean column.
  always_comb begin
    if (dsr_q == '0) begin
      steer_d = CMD_STOP;
    end else if (dvd_q < w3_q) begin
      steer_d = CMD_LEFT;
    end else if (dvd_q > w23_q) begin
      steer_d = CMD_RIGHT;
    end else begin
      steer_d = CMD_FORWARD;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      steer_q <= steer_d;
      mean_q  <= (dsr_q == '0) ? '0 : dvd_q;
      count_q <= dsr_q;
    end
  end

  assign stat_o.out_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o      = out_valid_q;
  assign steer_command_o  = steer_q;
  assign mean_column_o    = mean_q;
  assign white_count_o    = count_q;

endmodule

`default_nettype wire

// ===== sv/white_blob_centroid_steer.sv =====
// Top level of the white blob centroid steering block.
`default_nettype none
`include "assert_macros.svh"

// Takes one RGB pixel word per cycle in raster order, unless in_stall_o holds it
// off, and, on the word marked frame_end, returns one steering word built from the
// mean column of the pure white pixels in the middle third of the frame. A frame_end
// word starts a restoring divide, one quotient bit per step, followed by a load of
// the output register once it is free; pixels of the next frame are taken during the
// divide, but the next frame_end word is held off until the previous result
// has moved into the output register. A configuration write holds off input
// while it is taken and while the frame area and its thirds are recalculated
// by the area multiplier and then the divide-by-three multipliers.
module white_blob_centroid_steer (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [wbcs_pkg::PIX_W-1:0]     red_level_i,
  input  wire logic [wbcs_pkg::PIX_W-1:0]     green_level_i,
  input  wire logic [wbcs_pkg::PIX_W-1:0]     blue_level_i,
  input  wire logic                           frame_end_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [wbcs_pkg::CMD_W-1:0]          steer_command_o,
  output logic [wbcs_pkg::MEAN_W-1:0]         mean_column_o,
  output logic [wbcs_pkg::CNT_W-1:0]          white_count_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [wbcs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [wbcs_pkg::DIM_W-1:0]     cfg_data_i
);
  import wbcs_pkg::*;

  wbcs_cmd_t  cmd;
  wbcs_stat_t stat;

  wbcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .frame_end_i (frame_end_i),
    .in_stall_o  (in_stall_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  wbcs_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .red_level_i     (red_level_i),
    .green_level_i   (green_level_i),
    .blue_level_i    (blue_level_i),
    .frame_end_i     (frame_end_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .steer_command_o (steer_command_o),
    .mean_column_o   (mean_column_o),
    .white_count_o   (white_count_o)
  );

  // A stop word carries a zero mean, and stop is given exactly when no white pixel was seen.
  `WBCS_ASSERT_NOW(a_stop_mean_zero, out_valid_o && (steer_command_o == CMD_STOP), mean_column_o == '0)
  `WBCS_ASSERT_NOW(a_stop_iff_empty, out_valid_o, (steer_command_o == CMD_STOP) == (white_count_o == '0))
  // Pixels are held off while a configuration write is taken and while limits are recalculated.
  `WBCS_ASSERT_NOW(a_cfg_blocks_input, cfg_valid_i && cfg_ready_o, in_stall_o)
  `WBCS_ASSERT_NEXT(a_recalc_blocks_input, cfg_valid_i && cfg_ready_o, in_stall_o && !cfg_ready_o)

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the white blob centroid steering block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wbcs_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 20;

  // One pixel word and one steering word.
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_end;
  } pixel_t;

  typedef struct packed {
    steer_e            cmd;
    logic [MEAN_W-1:0] mean;
    logic [CNT_W-1:0]  count;
  } steer_word_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [PIX_W-1:0]     red_level_i;
  logic [PIX_W-1:0]     green_level_i;
  logic [PIX_W-1:0]     blue_level_i;
  logic                 frame_end_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [CMD_W-1:0]     steer_command_o;
  logic [MEAN_W-1:0]    mean_column_o;
  logic [CNT_W-1:0]     white_count_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DIM_W-1:0]     cfg_data_i;

  white_blob_centroid_steer i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .red_level_i     (red_level_i),
    .green_level_i   (green_level_i),
    .blue_level_i    (blue_level_i),
    .frame_end_i     (frame_end_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .steer_command_o (steer_command_o),
    .mean_column_o   (mean_column_o),
    .white_count_o   (white_count_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Pixel words waiting to be sent and steering words still owed by the block.
  pixel_t      pixel_queue[$];
  steer_word_t steer_due[$];
  pixel_t      next_pixel;
  steer_word_t due_word;
  logic        pixel_taken = 1'b0;

  int unsigned send_idle_pct = 30;
  int unsigned recv_idle_pct = 88;

  // Shadow of the frame registers and of the accumulation state.
  logic [DIM_W-1:0] shadow_width  = DIM_W'(RESET_WIDTH);
  logic [DIM_W-1:0] shadow_height = DIM_W'(RESET_HEIGHT);
  logic [COL_W-1:0] col_pos       = '0;
  logic [IDX_W-1:0] pix_index     = '0;
  logic [SUM_W-1:0] col_sum       = '0;
  logic [CNT_W-1:0] white_total   = '0;

  int mismatches    = 0;
  int cycle_count   = 0;
  int pixels_sent   = 0;
  int words_checked = 0;
  int settings_used = 0;
  int cmd_seen[4]   = '{0, 0, 0, 0};

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned clamp_dim(input logic [DIM_W-1:0] raw,
                                                input longint unsigned top);
    if (raw == 0) return 1;
    if (raw > top) return top;
    return raw;
  endfunction

  // Update the centroid state for one accepted pixel and owe a steering word on
  // the last pixel of the frame.
  task automatic accumulate_centroid(input pixel_t px);
    longint unsigned w, h, area, lo, hi, mean;
    steer_word_t word;
    w = clamp_dim(shadow_width, MAX_WIDTH);
    h = clamp_dim(shadow_height, MAX_HEIGHT);
    area = w * h;
    lo = area / 3;
    hi = (area * 2) / 3;
    if (pix_index >= lo && pix_index < hi && px.red == WHITE_LEVEL &&
        px.green == WHITE_LEVEL && px.blue == WHITE_LEVEL) begin
      if (white_total < CNT_MAX) white_total = white_total + 1'b1;
      if (col_sum > SUM_MAX - col_pos) col_sum = SUM_MAX;
      else col_sum = col_sum + col_pos;
    end
    if (pix_index < IDX_MAX) pix_index = pix_index + 1'b1;
    if (col_pos + 64'd1 >= w) col_pos = '0;
    else col_pos = col_pos + 1'b1;
    if (!px.frame_end) return;
    word.cmd = CMD_STOP;
    mean = 0;
    if (white_total != 0) begin
      mean = col_sum / white_total;
      if (mean < w / 3) word.cmd = CMD_LEFT;
      else if (mean > (w * 2) / 3) word.cmd = CMD_RIGHT;
      else word.cmd = CMD_FORWARD;
    end
    word.mean = MEAN_W'(mean);
    word.count = white_total;
    steer_due.push_back(word);
    col_pos = '0;
    pix_index = '0;
    col_sum = '0;
    white_total = '0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Pixel driver: a word is held until it is taken, idle gaps are drawn at random.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || pixel_taken)) begin
      if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_pixel = pixel_queue.pop_front();
        in_valid_i    <= 1'b1;
        red_level_i   <= next_pixel.red;
        green_level_i <= next_pixel.green;
        blue_level_i  <= next_pixel.blue;
        frame_end_i   <= next_pixel.frame_end;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= rst_ni && ($urandom_range(99) < recv_idle_pct);
  end

  // Monitor: predicts on every accepted pixel word and checks every steering word.
  always @(posedge clk_i) begin
    cycle_count++;
    if (!rst_ni) begin
      pixel_taken <= 1'b0;
    end else begin
      pixel_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        accumulate_centroid({red_level_i, green_level_i, blue_level_i, frame_end_i});
        pixels_sent++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (steer_due.size() == 0) begin
          report_mismatch($sformatf("steering word cmd %0d mean %0d count %0d not owed",
                                    steer_command_o, mean_column_o, white_count_o));
        end else begin
          due_word = steer_due.pop_front();
          if (steer_command_o !== due_word.cmd)
            report_mismatch($sformatf("steer_command got %0d want %0d",
                                      steer_command_o, due_word.cmd));
          if (mean_column_o !== due_word.mean)
            report_mismatch($sformatf("mean_column got %0d want %0d",
                                      mean_column_o, due_word.mean));
          if (white_count_o !== due_word.count)
            report_mismatch($sformatf("white_count got %0d want %0d",
                                      white_count_o, due_word.count));
          words_checked++;
          cmd_seen[due_word.cmd]++;
        end
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic pixel_t make_pixel(input int r, input int g, input int b,
                                        input bit last);
    make_pixel = {PIX_W'(r), PIX_W'(g), PIX_W'(b), last};
  endfunction

  // Random pixel: fully white at the given rate, otherwise channels that are often
  // 255 on their own so that near-white pixels turn up.
  function automatic pixel_t rand_pixel(input int unsigned white_pct, input bit last);
    pixel_t px;
    if ($urandom_range(99) < white_pct) begin
      px = make_pixel(255, 255, 255, last);
    end else begin
      px.red   = ($urandom_range(3) == 0) ? 8'hFF : PIX_W'($urandom_range(255));
      px.green = ($urandom_range(3) == 0) ? 8'hFF : PIX_W'($urandom_range(255));
      px.blue  = ($urandom_range(3) == 0) ? 8'hFF : PIX_W'($urandom_range(255));
      px.frame_end = last;
    end
    return px;
  endfunction

  task automatic push_px(input int r, input int g, input int b, input bit last);
    pixel_queue.push_back(make_pixel(r, g, b, last));
  endtask

  // Queue one frame whose length is mostly the full frame, sometimes cut short
  // and sometimes running past the end; a frame over 64 pixels is always cut to 1 to 24.
  task automatic queue_frame(input longint unsigned w, input longint unsigned h,
                             output int len);
    longint unsigned area;
    int unsigned white_pct;
    int roll;
    area = w * h;
    roll = $urandom_range(99);
    if (area > 64) len = $urandom_range(1, 24);
    else if (roll < 70) len = int'(area);
    else if (roll < 85) len = $urandom_range(1, int'(area));
    else len = int'(area) + $urandom_range(1, 6);
    case ($urandom_range(3))
      0:       white_pct = 0;
      1:       white_pct = 25;
      2:       white_pct = 60;
      default: white_pct = 95;
    endcase
    for (int k = 0; k < len; k++) pixel_queue.push_back(rand_pixel(white_pct, k == len - 1));
  endtask

  // Hold the sender back until every owed word has come and the block has settled.
  task automatic drain;
    while (pixel_queue.size() != 0 || in_valid_i || steer_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_FRAME_WIDTH) shadow_width = val;
    else shadow_height = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    drain();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    settings_used++;
  endtask

  // Stimulus sequence.
  initial begin
    longint unsigned fw, fh;
    int placed, len, frames;
    in_valid_i    = 1'b0;
    red_level_i   = '0;
    green_level_i = '0;
    blue_level_i  = '0;
    frame_end_i   = 1'b0;
    out_stall_i   = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_FRAME_WIDTH;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset frame size: a lone white pixel lies before the middle third.
    push_px(255, 255, 255, 1);

    // 4x3 frame, middle third is row 1; near-white pixels must not count.
    set_frame(4, 3);
    for (int k = 0; k < 4; k++) push_px(255, 255, 255, 0);
    push_px(255, 255, 254, 0);
    push_px(254, 255, 255, 0);
    push_px(255, 254, 255, 0);
    push_px(255, 255, 255, 1);
    // Frame ended early inside the region on a white pixel: mean 0, turn left.
    for (int k = 0; k < 4; k++) push_px(0, 0, 0, 0);
    push_px(255, 255, 255, 0);
    push_px(255, 255, 255, 1);
    // Full frame with whites in row 2 as well: forward.
    for (int k = 0; k < 4; k++) push_px(128, 64, 32, 0);
    push_px(0, 0, 0, 0);
    push_px(255, 255, 255, 0);
    push_px(255, 255, 255, 0);
    push_px(0, 255, 255, 0);
    for (int k = 0; k < 3; k++) push_px(255, 255, 255, 0);
    push_px(255, 255, 255, 1);
    // One-pixel frame: stop.
    push_px(255, 255, 255, 1);

    // Oversized width and zero height clamp to 4096 by 1.
    set_frame(DIM_W'(8191), 0);
    for (int k = 0; k < 3; k++) push_px(255, 255, 255, k == 2);

    // 32x3 frame: whites at the far columns of the middle row turn right.
    set_frame(32, 3);
    for (int k = 0; k < 96; k++) begin
      if ((k / 32 == 1 && k % 32 >= 30) || k == 31) push_px(255, 255, 255, k == 95);
      else push_px(k % 255, 255, 255, k == 95);
    end

    // Zero width and oversized height clamp to 1 by 4096.
    set_frame(0, DIM_W'(8191));
    push_px(255, 255, 255, 0);
    push_px(255, 255, 255, 1);

    // Random frames under each idle pattern.
    for (int mode = 0; mode < 3; mode++) begin
      drain();
      case (mode)
        0:       begin send_idle_pct = 30; recv_idle_pct = 88; end
        1:       begin send_idle_pct = 88; recv_idle_pct = 30; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      placed = 0;
      while (placed < 160) begin
        if ($urandom_range(99) < 85) begin
          fw = $urandom_range(1, 8);
          fh = $urandom_range(1, 6);
        end else begin
          case ($urandom_range(3))
            0:       begin fw = 0;                          fh = $urandom_range(1, 6); end
            1:       begin fw = $urandom_range(4096, 8191); fh = 1;                    end
            2:       begin fw = $urandom_range(1, 8);       fh = 0;                    end
            default: begin fw = $urandom_range(1, 8);       fh = $urandom_range(4096, 8191); end
          endcase
        end
        set_frame(DIM_W'(fw), DIM_W'(fh));
        frames = $urandom_range(1, 4);
        for (int f = 0; f < frames; f++) begin
          queue_frame(clamp_dim(DIM_W'(fw), MAX_WIDTH), clamp_dim(DIM_W'(fh), MAX_HEIGHT), len);
          placed += len;
        end
      end
    end

    drain();
    if (steer_due.size() != 0)
      report_mismatch($sformatf("%0d steering words never arrived", steer_due.size()));
    $display("Covered %0d pixel words and %0d steering words over %0d frame sizes.",
             pixels_sent, words_checked, settings_used);
    $display("Commands seen: stop %0d, left %0d, forward %0d, right %0d; %0d mismatches.",
             cmd_seen[CMD_STOP], cmd_seen[CMD_LEFT], cmd_seen[CMD_FORWARD],
             cmd_seen[CMD_RIGHT], mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
